[design/adll_pkg.sv]
`timescale 1ns / 1ps

package adll_pkg;

  // Width of an entry number and of a link value.
  localparam int ID_W = 7;

  // Microprogram step counter.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  // Microprogram layout. The dump loop falls through into the idle step, and
  // the remove sequence falls through into the plain acknowledge step.
  localparam step_t S_D_FRONT  = 5'd0;
  localparam step_t S_D_LOAD   = 5'd1;
  localparam step_t S_D_EMIT   = 5'd2;
  localparam step_t S_IDLE     = 5'd3;
  localparam step_t S_DISPATCH = 5'd4;
  localparam step_t S_I_FULL   = 5'd5;
  localparam step_t S_I_NB     = 5'd6;
  localparam step_t S_I_WR1    = 5'd7;
  localparam step_t S_I_WR2    = 5'd8;
  localparam step_t S_I_DONE   = 5'd9;
  localparam step_t S_R_CHK    = 5'd10;
  localparam step_t S_R_WR1    = 5'd11;
  localparam step_t S_R_WR2    = 5'd12;
  localparam step_t S_E_OK     = 5'd13;
  localparam step_t S_E_FULL   = 5'd14;
  localparam step_t S_E_NB     = 5'd15;
  localparam step_t S_E_RABS   = 5'd16;

  typedef enum logic [1:0] {
    CMD_INSERT,
    CMD_REMOVE,
    CMD_DUMP
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_REMOVE_ABSENT,
    ST_FULL,
    ST_NEIGHBOR_ABSENT
  } status_e;

  // Link table read address source.
  typedef enum logic [1:0] {
    RA_NONE,
    RA_NODE,
    RA_FRONT,
    RA_NEXT
  } ra_e;

  // Link table write patterns.
  typedef enum logic [2:0] {
    WR_NONE,
    WR_INS_FRESH,
    WR_INS_NEIGHBOR,
    WR_REM_UNLINK,
    WR_REM_CLEAR
  } wr_e;

  // Dump cursor load.
  typedef enum logic [1:0] {
    CUR_HOLD,
    CUR_FRONT,
    CUR_NEXT
  } cur_e;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_FRESH,
    ID_CUR
  } id_e;

  typedef enum logic {
    LAST_ONE,
    LAST_END
  } last_e;

  // Jump conditions. A true condition loads the target, otherwise the step
  // counter advances by one.
  typedef enum logic [2:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_WAIT_ACCEPT,
    JC_FULL,
    JC_NODE_ABSENT,
    JC_FRONT_ABSENT,
    JC_MORE,
    JC_DISPATCH
  } jc_e;

  typedef struct packed {
    ra_e     ra;
    wr_e     wr;
    cur_e    cur;
    logic    inc_num;
    logic    emit;
    id_e     id;
    last_e   last;
    status_e status;
    jc_e     jc;
    step_t   target;
  } ctrl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic       accept;
    logic       slot_free;
    logic       full;
    logic       node_absent;
    logic       front_absent;
    logic       dump_end;
    logic [1:0] cmd;
  } flags_t;

  function automatic ctrl_t cw(ra_e ra, wr_e wr, cur_e cur, logic inc_num, logic emit,
                               id_e id, last_e last, status_e status, jc_e jc,
                               step_t target);
    return ctrl_t'{ra, wr, cur, inc_num, emit, id, last, status, jc, target};
  endfunction

  // Control store.
  function automatic ctrl_t micro_word(step_t s);
    ctrl_t w;
    unique case (s)
      S_D_FRONT:  w = cw(RA_FRONT, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NEXT, S_IDLE);
      S_D_LOAD:   w = cw(RA_NEXT, WR_NONE, CUR_FRONT, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_FRONT_ABSENT, S_E_OK);
      S_D_EMIT:   w = cw(RA_NEXT, WR_NONE, CUR_NEXT, 1'b0, 1'b1, ID_CUR, LAST_END,
                         ST_OK, JC_MORE, S_D_EMIT);
      S_IDLE:     w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_WAIT_ACCEPT, S_IDLE);
      S_DISPATCH: w = cw(RA_NODE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_DISPATCH, S_IDLE);
      S_I_FULL:   w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_FULL, S_E_FULL);
      S_I_NB:     w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NODE_ABSENT, S_E_NB);
      S_I_WR1:    w = cw(RA_NONE, WR_INS_FRESH, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NEXT, S_IDLE);
      S_I_WR2:    w = cw(RA_NONE, WR_INS_NEIGHBOR, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NEXT, S_IDLE);
      S_I_DONE:   w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b1, 1'b1, ID_FRESH, LAST_ONE,
                         ST_OK, JC_ALWAYS, S_IDLE);
      S_R_CHK:    w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NODE_ABSENT, S_E_RABS);
      S_R_WR1:    w = cw(RA_NONE, WR_REM_UNLINK, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NEXT, S_IDLE);
      S_R_WR2:    w = cw(RA_NONE, WR_REM_CLEAR, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_NEXT, S_IDLE);
      S_E_OK:     w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b1, ID_ZERO, LAST_ONE,
                         ST_OK, JC_ALWAYS, S_IDLE);
      S_E_FULL:   w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b1, ID_ZERO, LAST_ONE,
                         ST_FULL, JC_ALWAYS, S_IDLE);
      S_E_NB:     w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b1, ID_ZERO, LAST_ONE,
                         ST_NEIGHBOR_ABSENT, JC_ALWAYS, S_IDLE);
      S_E_RABS:   w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b1, ID_ZERO, LAST_ONE,
                         ST_REMOVE_ABSENT, JC_ALWAYS, S_IDLE);
      default:    w = cw(RA_NONE, WR_NONE, CUR_HOLD, 1'b0, 1'b0, ID_ZERO, LAST_ONE,
                         ST_OK, JC_ALWAYS, S_IDLE);
    endcase
    return w;
  endfunction

  // Entry step of each command; the unused command code goes straight back to idle.
  function automatic step_t dispatch_step(logic [1:0] cmd);
    step_t s;
    unique case (cmd)
      CMD_INSERT: s = S_I_FULL;
      CMD_REMOVE: s = S_R_CHK;
      CMD_DUMP:   s = S_D_FRONT;
      default:    s = S_IDLE;
    endcase
    return s;
  endfunction

endpackage

[design/adll_ram.sv]
`timescale 1ns / 1ps

module adll_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 65
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port that holds while not enabled.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/adll_seq.sv]
`timescale 1ns / 1ps

module adll_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  adll_pkg::flags_t flags_i,
  output adll_pkg::ctrl_t  ctrl_o,
  output logic            go_o,
  output logic            idle_o
);

  import adll_pkg::*;

  step_t pc_q, pc_d;
  logic  stall;

  // Control word of the current step.
  assign ctrl_o = micro_word(pc_q);

  // An emitting step waits until the output register can take its item.
  assign stall  = ctrl_o.emit && !flags_i.slot_free;
  assign go_o   = !stall;
  assign idle_o = (pc_q == S_IDLE);

  // Next step: hold on a stall, otherwise take the conditional jump or advance.
  always_comb begin
    pc_d = pc_q + step_t'(1);
    if (stall) begin
      pc_d = pc_q;
    end else begin
      unique case (ctrl_o.jc)
        JC_NEXT:         pc_d = pc_q + step_t'(1);
        JC_ALWAYS:       pc_d = ctrl_o.target;
        JC_WAIT_ACCEPT:  if (!flags_i.accept) pc_d = ctrl_o.target;
        JC_FULL:         if (flags_i.full) pc_d = ctrl_o.target;
        JC_NODE_ABSENT:  if (flags_i.node_absent) pc_d = ctrl_o.target;
        JC_FRONT_ABSENT: if (flags_i.front_absent) pc_d = ctrl_o.target;
        JC_MORE:         if (!flags_i.dump_end) pc_d = ctrl_o.target;
        JC_DISPATCH:     pc_d = dispatch_step(flags_i.cmd);
        default:         pc_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[design/array_doubly_linked_list_core.sv]
`timescale 1ns / 1ps
// Ordered list of numbered entries kept as a doubly linked list in two link
// tables. Commands arrive on the input channel (cmd_i, node_i, side_i under
// in_valid_i / in_ready_o); results leave on the output channel (entry_id_o,
// last_o, status_o under out_valid_o / out_ready_i). One item is worked on at
// a time; in_ready_o is high only while the sequencer sits in its idle step.
// Each link table has a single registered read port. After its first entry,
// a dump delivers one entry per cycle while the receiver keeps up. An unused
// command code gives no result.
// Reset leaves entry 1 alone in the list with the next number at 2; per-entry
// valid bits in flip-flops make the link tables read as cleared right away.
// A stalled receiver holds the result in the output register and the
// sequencer waits in its emitting step, so nothing is lost or repeated.
module array_doubly_linked_list_core #(
  parameter int CAPACITY = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_i,
  input  logic [6:0] node_i,
  input  logic       side_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] entry_id_o,
  output logic       last_o,
  output logic [1:0] status_o
);

  import adll_pkg::*;

  localparam int DEPTH = CAPACITY + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(CAPACITY);

  typedef logic [ID_W-1:0] id_t;
  typedef logic [AW-1:0]   addr_t;

  ctrl_t  ctrl;
  flags_t flags;
  logic   go;
  logic   idle;
  logic   accept;

  // Command registers.
  logic [1:0] cmd_q;
  id_t        node_q;
  logic       side_q;

  // List state.
  id_t front_q, front_d;
  id_t num_q;

  // Dump cursor.
  id_t           cur_q;
  id_t           nx_q;
  logic [CW-1:0] count_q;

  // Link tables with valid bits and registered read side flags.
  logic [DEPTH-1:0] pvalid_q, nvalid_q;
  logic             pval_q, nval_q, ra_one_q;
  id_t              prd, nrd, rp, rn;
  addr_t            raddr;
  logic             re;
  logic             pwe, nwe;
  id_t              pw_id, nw_id, pwdata, nwdata;
  addr_t            pwaddr, nwaddr;

  // Insert and remove helpers.
  id_t  o_link, o_sel;
  logic o_ne_k;

  // Output register.
  logic          out_valid_q;
  id_t           entry_id_q;
  logic          last_q;
  logic [1:0]    status_q;
  logic          slot_free;
  logic          emit_fire;
  id_t           emit_id;
  logic          dump_end;

  function automatic logic in_rng(id_t v);
    return (v != '0) && (v <= id_t'(CAPACITY));
  endfunction

  function automatic addr_t to_addr(id_t v);
    return in_rng(v) ? v[AW-1:0] : '0;
  endfunction

  adll_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .flags_i(flags),
    .ctrl_o (ctrl),
    .go_o   (go),
    .idle_o (idle)
  );

  assign in_ready_o = idle;
  assign accept     = in_valid_i && in_ready_o;
  assign slot_free  = !out_valid_q || out_ready_i;
  assign emit_fire  = go && ctrl.emit;

  // Link data as seen after reset: entry 1 links to itself, others read 0.
  assign rp = pval_q ? prd : (ra_one_q ? id_t'(1) : '0);
  assign rn = nval_q ? nrd : (ra_one_q ? id_t'(1) : '0);

  // Dump ends on a self link, an absent successor or the capacity count.
  assign dump_end = (nx_q == cur_q) || !(in_rng(nx_q) && (rp != '0)) ||
                    (count_q == CW'(CAPACITY - 1));

  assign flags.accept       = accept;
  assign flags.slot_free    = slot_free;
  assign flags.full         = (num_q > id_t'(CAPACITY));
  assign flags.node_absent  = !(in_rng(node_q) && (rp != '0));
  assign flags.front_absent = !(in_rng(front_q) && (rp != '0));
  assign flags.dump_end     = dump_end;
  assign flags.cmd          = cmd_q;

  // Read address selection.
  always_comb begin
    unique case (ctrl.ra)
      RA_NODE:  raddr = to_addr(node_q);
      RA_FRONT: raddr = to_addr(front_q);
      RA_NEXT:  raddr = to_addr(rn);
      default:  raddr = '0;
    endcase
  end

  assign re = go && (ctrl.ra != RA_NONE);

  // The neighbor's link on the insert side, and what the new entry links to.
  assign o_link = side_q ? rn : rp;
  assign o_ne_k = (o_link != node_q);
  assign o_sel  = o_ne_k ? o_link : num_q;

  // Link table writes and front updates for each write pattern.
  always_comb begin
    pwe     = 1'b0;
    nwe     = 1'b0;
    pw_id   = node_q;
    nw_id   = node_q;
    pwdata  = '0;
    nwdata  = '0;
    front_d = front_q;
    unique case (ctrl.wr)
      WR_INS_FRESH: begin
        pwe    = 1'b1;
        nwe    = 1'b1;
        pw_id  = num_q;
        nw_id  = num_q;
        pwdata = side_q ? node_q : o_sel;
        nwdata = side_q ? o_sel : node_q;
      end
      WR_INS_NEIGHBOR: begin
        pwe    = side_q ? o_ne_k : 1'b1;
        nwe    = side_q ? 1'b1 : o_ne_k;
        pw_id  = side_q ? o_link : node_q;
        nw_id  = side_q ? node_q : o_link;
        pwdata = num_q;
        nwdata = num_q;
        if (!side_q && !o_ne_k) begin
          front_d = num_q;
        end
      end
      WR_REM_UNLINK: begin
        // rp is the entry before the removed one, rn the entry after it.
        pwe    = (rn != node_q);
        nwe    = (rp != node_q);
        pw_id  = rn;
        nw_id  = rp;
        pwdata = (rp == node_q) ? rn : rp;
        nwdata = (rn == node_q) ? rp : rn;
        if (rp == node_q) begin
          front_d = (rn == node_q) ? id_t'(0) : rn;
        end
      end
      WR_REM_CLEAR: begin
        pwe = 1'b1;
        nwe = 1'b1;
      end
      default: begin
      end
    endcase
    pwe = pwe && go;
    nwe = nwe && go;
  end

  assign pwaddr = pw_id[AW-1:0];
  assign nwaddr = nw_id[AW-1:0];

  adll_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i  (clk_i),
    .we_i   (pwe),
    .waddr_i(pwaddr),
    .wdata_i(pwdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(prd)
  );

  adll_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_next_ram (
    .clk_i  (clk_i),
    .we_i   (nwe),
    .waddr_i(nwaddr),
    .wdata_i(nwdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(nrd)
  );

  // Result entry number.
  always_comb begin
    unique case (ctrl.id)
      ID_FRESH: emit_id = num_q;
      ID_CUR:   emit_id = cur_q;
      default:  emit_id = '0;
    endcase
  end

  // Control state: list head, next number, valid bits, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= id_t'(1);
      num_q       <= id_t'(2);
      pvalid_q    <= '0;
      nvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      if (go && ctrl.inc_num) begin
        num_q <= num_q + id_t'(1);
      end
      if (pwe) begin
        pvalid_q[pwaddr] <= 1'b1;
      end
      if (nwe) begin
        nvalid_q[nwaddr] <= 1'b1;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: command, read side flags, dump cursor and result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_i;
      node_q <= node_i;
      side_q <= side_i;
    end
    if (re) begin
      pval_q   <= pvalid_q[raddr];
      nval_q   <= nvalid_q[raddr];
      ra_one_q <= (raddr == addr_t'(1));
    end
    if (go) begin
      unique case (ctrl.cur)
        CUR_FRONT: begin
          cur_q   <= front_q;
          nx_q    <= rn;
          count_q <= '0;
        end
        CUR_NEXT: begin
          cur_q   <= nx_q;
          nx_q    <= rn;
          count_q <= count_q + CW'(1);
        end
        default: begin
        end
      endcase
    end
    if (emit_fire) begin
      entry_id_q <= emit_id;
      last_q     <= (ctrl.last == LAST_ONE) ? 1'b1 : dump_end;
      status_q   <= ctrl.status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign entry_id_o  = entry_id_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule
